[rtl/core/cwrd_pkg.sv]
package cwrd_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int CSR_W           = 6;
   localparam int SQ_W            = 31;
   localparam int SUM_W           = 38;
   localparam int FRAC_W          = 16;
   localparam int EXP_W           = 6;
   localparam int LOG_W           = EXP_W + FRAC_W;
   localparam int MANT_W          = 31;
   localparam int LEVEL_W         = 16;
   localparam int PROD_W          = 48;
   localparam int MAX_HALF_WINDOW = 63;
   localparam int HALF_WINDOW_RST = 32;

   // 2560*log10(2) in Q16
   localparam logic [25:0]        DB_SCALE_Q16 = 26'd50504453;
   localparam logic [LEVEL_W-1:0] LEVEL_FLOOR  = 16'h8000;
   localparam logic [14:0]        MAG_MAX      = 15'h7FFF;
   // 0 dB reference: log2 of full-scale square, Q16
   localparam logic [23:0]        LOG_FULL_SCALE = 24'(30 * 65536);

   typedef enum logic [2:0] {
      LG_IDLE,
      LG_NORM,
      LG_SQ,
      LG_BIT,
      LG_DONE
   } log_state_type;

   typedef enum logic [2:0] {
      LV_IDLE,
      LV_LOGC,
      LV_WAITC,
      LV_LOGS,
      LV_WAITS,
      LV_MUL,
      LV_FIN,
      LV_DONE
   } lvl_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ,
      S_UPD,
      S_DECIDE,
      S_LVL,
      S_LWAIT,
      S_EMIT,
      S_CHK,
      S_RMSQ,
      S_RMSUB
   } top_state_type;

endpackage

[rtl/core/cwrd_log2.sv]
// log2 in Q16: bit-serial normalize, then one squaring step per fraction bit
module cwrd_log2 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cwrd_pkg::SUM_W-1:0] value,
   output logic                       done,
   output logic [cwrd_pkg::LOG_W-1:0] result
);

   cwrd_pkg::log_state_type state_ff, state_in;

   logic [cwrd_pkg::SUM_W-1:0]  norm_ff;
   logic [cwrd_pkg::EXP_W-1:0]  exp_ff;
   logic [cwrd_pkg::MANT_W-1:0] mant_ff;
   logic [2*cwrd_pkg::MANT_W-1:0] sq_ff;
   logic [cwrd_pkg::FRAC_W-1:0] frac_ff;
   logic [3:0]                  bit_cnt_ff;
   logic [cwrd_pkg::MANT_W:0]   m2;

   assign m2 = sq_ff[2*cwrd_pkg::MANT_W-1:cwrd_pkg::MANT_W-1];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cwrd_pkg::LG_IDLE: if (start) state_in = cwrd_pkg::LG_NORM;
         cwrd_pkg::LG_NORM: if (norm_ff[cwrd_pkg::SUM_W-1]) state_in = cwrd_pkg::LG_SQ;
         cwrd_pkg::LG_SQ:   state_in = cwrd_pkg::LG_BIT;
         cwrd_pkg::LG_BIT:  state_in = (bit_cnt_ff == 4'd15) ? cwrd_pkg::LG_DONE
                                                             : cwrd_pkg::LG_SQ;
         cwrd_pkg::LG_DONE: state_in = cwrd_pkg::LG_IDLE;
         default:           state_in = cwrd_pkg::LG_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == cwrd_pkg::LG_DONE);
   end

   assign result = {exp_ff, frac_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwrd_pkg::LG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         cwrd_pkg::LG_IDLE: begin
            norm_ff <= value;
            exp_ff  <= cwrd_pkg::EXP_W'(cwrd_pkg::SUM_W - 1);
         end
         cwrd_pkg::LG_NORM: begin
            if (norm_ff[cwrd_pkg::SUM_W-1]) begin
               mant_ff    <= norm_ff[cwrd_pkg::SUM_W-1 -: cwrd_pkg::MANT_W];
               bit_cnt_ff <= '0;
            end else begin
               norm_ff <= {norm_ff[cwrd_pkg::SUM_W-2:0], 1'b0};
               exp_ff  <= exp_ff - 1'b1;
            end
         end
         cwrd_pkg::LG_SQ: begin
            sq_ff <= mant_ff * mant_ff;
         end
         cwrd_pkg::LG_BIT: begin
            frac_ff    <= {frac_ff[cwrd_pkg::FRAC_W-2:0], m2[cwrd_pkg::MANT_W]};
            mant_ff    <= m2[cwrd_pkg::MANT_W] ? m2[cwrd_pkg::MANT_W:1]
                                               : m2[cwrd_pkg::MANT_W-1:0];
            bit_cnt_ff <= bit_cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

endmodule

[rtl/core/cwrd_level.sv]
// level_db = -10*log10(sum / count / 2^30) in 1/256 dB
module cwrd_level #(
   parameter int CNT_W = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cwrd_pkg::SUM_W-1:0]   sum,
   input  logic [CNT_W-1:0]             count,
   output logic                         done,
   output logic [cwrd_pkg::LEVEL_W-1:0] level
);

   cwrd_pkg::lvl_state_type state_ff, state_in;

   logic [cwrd_pkg::SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [cwrd_pkg::LOG_W-1:0]   lc_ff;
   logic [cwrd_pkg::LOG_W-1:0]   n_ff;
   logic [cwrd_pkg::PROD_W-1:0]  prod_ff;
   logic [cwrd_pkg::LEVEL_W-1:0] level_ff;

   logic                         log_start;
   logic [cwrd_pkg::SUM_W-1:0]   log_value;
   logic                         log_done;
   logic [cwrd_pkg::LOG_W-1:0]   log_result;
   logic [23:0]                  n_full;
   logic [cwrd_pkg::PROD_W:0]    rnd;
   logic [16:0]                  mag;
   logic [14:0]                  mag_sat;

   cwrd_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .value  (log_value),
      .done   (log_done),
      .result (log_result)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cwrd_pkg::LV_IDLE:  if (start) state_in = (sum == '0) ? cwrd_pkg::LV_DONE
                                                               : cwrd_pkg::LV_LOGC;
         cwrd_pkg::LV_LOGC:  state_in = cwrd_pkg::LV_WAITC;
         cwrd_pkg::LV_WAITC: if (log_done) state_in = cwrd_pkg::LV_LOGS;
         cwrd_pkg::LV_LOGS:  state_in = cwrd_pkg::LV_WAITS;
         cwrd_pkg::LV_WAITS: if (log_done) state_in = cwrd_pkg::LV_MUL;
         cwrd_pkg::LV_MUL:   state_in = cwrd_pkg::LV_FIN;
         cwrd_pkg::LV_FIN:   state_in = cwrd_pkg::LV_DONE;
         cwrd_pkg::LV_DONE:  state_in = cwrd_pkg::LV_IDLE;
         default:            state_in = cwrd_pkg::LV_IDLE;
      endcase
   end

   always_comb begin
      log_start = (state_ff == cwrd_pkg::LV_LOGC) || (state_ff == cwrd_pkg::LV_LOGS);
      log_value = (state_ff == cwrd_pkg::LV_LOGC) ? cwrd_pkg::SUM_W'(cnt_ff) : sum_ff;
      done      = (state_ff == cwrd_pkg::LV_DONE);
   end

   assign level   = level_ff;
   assign n_full  = cwrd_pkg::LOG_FULL_SCALE + 24'(lc_ff) - 24'(log_result);
   assign rnd     = {1'b0, prod_ff} + (cwrd_pkg::PROD_W + 1)'(64'h8000_0000);
   assign mag     = rnd[cwrd_pkg::PROD_W:32];
   assign mag_sat = (mag > 17'(cwrd_pkg::MAG_MAX)) ? cwrd_pkg::MAG_MAX : mag[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwrd_pkg::LV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // level_ff holds its value until the next start
   always_ff @(posedge clock) begin
      case (state_ff)
         cwrd_pkg::LV_IDLE: if (start) begin
            sum_ff   <= sum;
            cnt_ff   <= count;
            level_ff <= cwrd_pkg::LEVEL_FLOOR;
         end
         cwrd_pkg::LV_WAITC: if (log_done) lc_ff <= log_result;
         cwrd_pkg::LV_WAITS: if (log_done) begin
            n_ff <= n_full[23] ? '0 : n_full[cwrd_pkg::LOG_W-1:0];
         end
         cwrd_pkg::LV_MUL: prod_ff <= n_ff * cwrd_pkg::DB_SCALE_Q16;
         cwrd_pkg::LV_FIN: level_ff <= cwrd_pkg::LEVEL_W'(0) - {1'b0, mag_sat};
         default: ;
      endcase
   end

endmodule

[rtl/core/centered_window_rms_db_top.sv]
// Centered-window RMS level meter, output in 1/256 dB (0 = full scale).
// req_ carries one Q1.15 sample per beat; req_final_sample marks the last
// beat of a stream. rsp_ returns one level per sample, the level for a sample
// leaving half_window beats after it; the final beat flushes all pending
// levels, the last one flagged by rsp_last_level, and the stream state clears.
// csr_wr_en/csr_wr_data write half_window and also clear the stream state;
// write only while the block is idle.
// Timing: one sample is processed at a time. Accept, squaring and ring update
// run in turn; a sample with no level due frees the input after the decide
// step. For a level (not for zero energy) the shared log2 unit runs twice
// (a bit-serial normalize, then a squaring step and a bit step per fraction
// bit), plus the multiply/round; the level is then registered on rsp_.
// During a flush each extra level adds a check and at most one ring read
// and subtract. req_stall is high whenever a sample is in work.
// The result register holds a level while rsp_stall is high; a new sample can
// be accepted meanwhile, and work stalls only when the next level is ready.
// Reset (synchronous): half_window = 32, stream empty, no result pending.
// The sample ring needs no clearing; only entries of the current stream are read.
module centered_window_rms_db_top #(
   parameter int MAX_HALF_WINDOW = cwrd_pkg::MAX_HALF_WINDOW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cwrd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_final_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cwrd_pkg::LEVEL_W-1:0]  rsp_level_db,
   output logic                          rsp_last_level,
   input  logic                          csr_wr_en,
   input  logic [cwrd_pkg::CSR_W-1:0]    csr_wr_data
);

   localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
   localparam int PW    = $clog2(DEPTH);
   localparam int HW    = $clog2(MAX_HALF_WINDOW + 1);
   localparam int CW    = HW + 1;
   localparam int HRST  = (cwrd_pkg::HALF_WINDOW_RST > MAX_HALF_WINDOW) ?
                          MAX_HALF_WINDOW : cwrd_pkg::HALF_WINDOW_RST;

   cwrd_pkg::top_state_type state_ff, state_in;

   logic [cwrd_pkg::SAMPLE_W-1:0] ring_mem [DEPTH];
   logic [cwrd_pkg::SAMPLE_W-1:0] ring_rd_ff;

   logic [HW-1:0]                 half_ff;
   logic [cwrd_pkg::SUM_W-1:0]    sum_ff;
   logic [PW-1:0]                 wp_ff;
   logic [CW-1:0]                 seen_ff;
   logic [cwrd_pkg::SAMPLE_W-1:0] smp_ff;
   logic                          fin_ff;
   logic                          has_old_ff;
   logic [cwrd_pkg::SQ_W-1:0]     sq_new_ff;
   logic [cwrd_pkg::SQ_W-1:0]     sq_old_ff;
   logic [cwrd_pkg::SUM_W-1:0]    wsum_ff;
   logic [CW-1:0]                 span_ff;
   logic [HW-1:0]                 kk_ff;
   logic                          rsp_valid_ff;
   logic [cwrd_pkg::LEVEL_W-1:0]  rsp_level_ff;
   logic                          rsp_last_ff;

   logic                          ring_re;
   logic                          ring_we;
   logic                          lvl_start;
   logic                          lvl_done;
   logic [cwrd_pkg::LEVEL_W-1:0]  lvl_level;
   logic                          slot_free;
   logic                          accept;
   logic [CW-1:0]                 win_w;
   logic [PW:0]                   old_raw;
   logic [PW:0]                   rm_raw;
   logic [PW-1:0]                 old_addr;
   logic [PW-1:0]                 rm_addr;
   logic [PW-1:0]                 ring_raddr;
   logic [CW:0]                   target_raw;
   logic [CW-1:0]                 target;
   logic [HW-1:0]                 csr_half;
   logic                          emit_go;
   logic                          want_level;
   logic [2*cwrd_pkg::SAMPLE_W-1:0] sq_new_full;
   logic [2*cwrd_pkg::SAMPLE_W-1:0] sq_rd_full;

   cwrd_level #(
      .CNT_W (CW)
   ) u_level (
      .clock (clock),
      .reset (reset),
      .start (lvl_start),
      .sum   (wsum_ff),
      .count (span_ff),
      .done  (lvl_done),
      .level (lvl_level)
   );

   assign win_w      = {half_ff, 1'b1};
   assign old_raw    = (PW + 1)'(wp_ff) + (PW + 1)'(DEPTH) - (PW + 1)'(win_w);
   assign rm_raw     = (PW + 1)'(wp_ff) + (PW + 1)'(DEPTH) - (PW + 1)'(span_ff);
   assign old_addr   = (old_raw >= (PW + 1)'(DEPTH)) ?
                       PW'(old_raw - (PW + 1)'(DEPTH)) : old_raw[PW-1:0];
   assign rm_addr    = (rm_raw >= (PW + 1)'(DEPTH)) ?
                       PW'(rm_raw - (PW + 1)'(DEPTH)) : rm_raw[PW-1:0];
   assign target_raw = (CW + 1)'(kk_ff) + (CW + 1)'(half_ff) + 1'b1;
   assign target     = (target_raw > (CW + 1)'(seen_ff)) ? seen_ff : target_raw[CW-1:0];
   assign csr_half   = (int'(csr_wr_data) > MAX_HALF_WINDOW) ?
                       HW'(MAX_HALF_WINDOW) : HW'(csr_wr_data);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign want_level = fin_ff || (seen_ff >= CW'(half_ff) + 1'b1);
   assign sq_new_full = $signed(smp_ff) * $signed(smp_ff);
   assign sq_rd_full  = $signed(ring_rd_ff) * $signed(ring_rd_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cwrd_pkg::S_IDLE:   if (accept) state_in = cwrd_pkg::S_SQ;
         cwrd_pkg::S_SQ:     state_in = cwrd_pkg::S_UPD;
         cwrd_pkg::S_UPD:    state_in = cwrd_pkg::S_DECIDE;
         cwrd_pkg::S_DECIDE: state_in = want_level ? cwrd_pkg::S_LVL : cwrd_pkg::S_IDLE;
         cwrd_pkg::S_LVL:    state_in = cwrd_pkg::S_LWAIT;
         cwrd_pkg::S_LWAIT:  if (lvl_done) state_in = cwrd_pkg::S_EMIT;
         cwrd_pkg::S_EMIT: begin
            if (slot_free) begin
               state_in = (!fin_ff || kk_ff == '0) ? cwrd_pkg::S_IDLE : cwrd_pkg::S_CHK;
            end
         end
         cwrd_pkg::S_CHK:    state_in = (span_ff > target) ? cwrd_pkg::S_RMSQ
                                                           : cwrd_pkg::S_LVL;
         cwrd_pkg::S_RMSQ:   state_in = cwrd_pkg::S_RMSUB;
         cwrd_pkg::S_RMSUB:  state_in = cwrd_pkg::S_CHK;
         default:            state_in = cwrd_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = (state_ff != cwrd_pkg::S_IDLE);
      ring_re    = accept || ((state_ff == cwrd_pkg::S_CHK) && (span_ff > target));
      ring_raddr = (state_ff == cwrd_pkg::S_CHK) ? rm_addr : old_addr;
      ring_we    = (state_ff == cwrd_pkg::S_UPD);
      lvl_start  = (state_ff == cwrd_pkg::S_LVL);
      emit_go    = (state_ff == cwrd_pkg::S_EMIT) && slot_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level_db   = rsp_level_ff;
   assign rsp_last_level = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[wp_ff] <= smp_ff;
      if (ring_re) ring_rd_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cwrd_pkg::S_IDLE;
         half_ff      <= HW'(HRST);
         sum_ff       <= '0;
         wp_ff        <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit_go || (rsp_valid_ff && rsp_stall);
         if (csr_wr_en) begin
            half_ff <= csr_half;
            sum_ff  <= '0;
            wp_ff   <= '0;
            seen_ff <= '0;
         end else if (state_ff == cwrd_pkg::S_UPD) begin
            sum_ff  <= sum_ff - cwrd_pkg::SUM_W'(sq_old_ff) + cwrd_pkg::SUM_W'(sq_new_ff);
            wp_ff   <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            if (seen_ff < win_w) seen_ff <= seen_ff + 1'b1;
         end else if (emit_go && fin_ff && kk_ff == '0) begin
            sum_ff  <= '0;
            wp_ff   <= '0;
            seen_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         cwrd_pkg::S_IDLE: begin
            smp_ff     <= req_sample;
            fin_ff     <= req_final_sample;
            has_old_ff <= (seen_ff >= win_w);
         end
         cwrd_pkg::S_SQ: begin
            sq_new_ff <= sq_new_full[cwrd_pkg::SQ_W-1:0];
            sq_old_ff <= has_old_ff ? sq_rd_full[cwrd_pkg::SQ_W-1:0] : '0;
         end
         cwrd_pkg::S_DECIDE: begin
            wsum_ff <= sum_ff;
            span_ff <= seen_ff;
            kk_ff   <= (seen_ff - 1'b1 < CW'(half_ff)) ? HW'(seen_ff - 1'b1) : half_ff;
         end
         cwrd_pkg::S_EMIT: begin
            if (slot_free) begin
               rsp_level_ff <= lvl_level;
               rsp_last_ff  <= fin_ff && (kk_ff == '0);
               if (kk_ff != '0) kk_ff <= kk_ff - 1'b1;
            end
         end
         cwrd_pkg::S_RMSQ: sq_old_ff <= sq_rd_full[cwrd_pkg::SQ_W-1:0];
         cwrd_pkg::S_RMSUB: begin
            wsum_ff <= wsum_ff - cwrd_pkg::SUM_W'(sq_old_ff);
            span_ff <= span_ff - 1'b1;
         end
         default: ;
      endcase
   end

endmodule

[rtl/core/cwrd_checker.sv]
module cwrd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [cwrd_pkg::LEVEL_W-1:0]  rsp_level_db,
   input logic                          rsp_last_level
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_level_db)
                                 && $stable(rsp_last_level))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // levels never exceed full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level_db[15] || (rsp_level_db == '0))
      else $error("level above full scale");

   // one sample in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second sample taken while busy");

endmodule

bind centered_window_rms_db_top cwrd_checker u_cwrd_checker (.*);
